// ----- hdl/skf_pkg.sv -----
// Shared types, constants and the scancode-to-ASCII table for the keyboard buffer.
`timescale 1ns / 1ps

package skf_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int KEY_COUNT      = 128;
    localparam int CODE_W         = $clog2(KEY_COUNT);

    // Request kinds on the input channel
    typedef enum logic {
        REQ_SCAN = 1'b0,
        REQ_POP  = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t  req_type;
        logic [7:0] scancode;
    } skf_req_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       char_dropped;
        logic       up_held;
        logic       down_held;
        logic       left_held;
        logic       right_held;
        logic       fire_held;
        logic       quit_held;
        logic       enter_held;
    } skf_res_t;

    // Scancode constants
    localparam logic [7:0]        SC_PREFIX   = 8'hE0;
    localparam logic [7:0]        SC_BREAK    = 8'h80;
    localparam logic [CODE_W-1:0] KC_ESC      = CODE_W'(8'h01);
    localparam logic [CODE_W-1:0] KC_Q        = CODE_W'(8'h10);
    localparam logic [CODE_W-1:0] KC_ENTER    = CODE_W'(8'h1C);
    localparam logic [CODE_W-1:0] KC_LSHIFT   = CODE_W'(8'h2A);
    localparam logic [CODE_W-1:0] KC_Z        = CODE_W'(8'h2C);
    localparam logic [CODE_W-1:0] KC_RSHIFT   = CODE_W'(8'h36);
    localparam logic [CODE_W-1:0] KC_SPACE    = CODE_W'(8'h39);
    localparam logic [CODE_W-1:0] KC_UP       = CODE_W'(8'h48);
    localparam logic [CODE_W-1:0] KC_LEFT     = CODE_W'(8'h4B);
    localparam logic [CODE_W-1:0] KC_RIGHT    = CODE_W'(8'h4D);
    localparam logic [CODE_W-1:0] KC_DOWN     = CODE_W'(8'h50);
    localparam logic [CODE_W-1:0] KC_MAP_END  = CODE_W'(8'h36);
    localparam logic [7:0]        ASCII_SPACE = 8'h20;

    localparam int MAP_LEN = 54;

    // US layout, codes 0x00..0x35; zero means no character
    localparam logic [7:0] PLAIN_MAP [MAP_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2F
    };

    localparam logic [7:0] SHIFT_MAP [MAP_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
        8'h3E, 8'h3F
    };

    function automatic logic [7:0] to_ascii(input logic [CODE_W-1:0] code,
                                            input logic shifted);
        logic [5:0] idx;
        idx = code[5:0];
        if (code == KC_SPACE) begin
            return ASCII_SPACE;
        end else if (code >= KC_MAP_END) begin
            return 8'h00;
        end else if (shifted) begin
            return SHIFT_MAP[idx];
        end else begin
            return PLAIN_MAP[idx];
        end
    endfunction

endpackage

// ----- hdl/skf_ring.sv -----
// Character ring: synchronous memory with write and read pointers, one slot kept empty.
`timescale 1ns / 1ps

module skf_ring
    import skf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic [7:0] rd_data,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] write_ptr_inc, read_ptr_inc;

    assign write_ptr_inc = (write_ptr_reg == PTR_LAST) ? '0 : write_ptr_reg + 1'b1;
    assign read_ptr_inc  = (read_ptr_reg == PTR_LAST) ? '0 : read_ptr_reg + 1'b1;

    assign empty   = (write_ptr_reg == read_ptr_reg);
    assign full    = (write_ptr_inc == read_ptr_reg);
    assign rd_data = rd_data_reg;

    assign write_ptr_next = push ? write_ptr_inc : write_ptr_reg;
    assign read_ptr_next  = pop ? read_ptr_inc : read_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
        end else begin
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ring_mem[write_ptr_reg] <= push_data;
        end
    end

    // Read data holds until the next pop
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= ring_mem[read_ptr_reg];
        end
    end

endmodule

// ----- hdl/scancode_keyboard_fifo.sv -----
// Top level: set-1 scancode decoder with held-key tracking and a typed-character ring.
// Pipeline: an accepted request is registered in stage 1 and then in the output register,
// where m_valid rises once that output register is empty or being drained.
// Throughput: one request per cycle while the output is not stalled; one more request
// is taken while an earlier result waits at the output.
// Reset (aresetn low, synchronous): pointers, held keys and all valid flags clear;
// ring contents are not cleared, since only written slots are ever read.
`timescale 1ns / 1ps

module scancode_keyboard_fifo
    import skf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  skf_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output skf_res_t m_res
);

    // Only the keys that reach an output or pick the shift table are tracked;
    // the held bit of any other code is never observed.
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
        logic z;
        logic space;
        logic q;
        logic esc;
        logic enter;
        logic lshift;
        logic rshift;
    } held_keys_t;

    // Stage 1 flags travel alongside the ring read data
    typedef struct packed {
        logic char_valid;
        logic char_dropped;
        logic up_held;
        logic down_held;
        logic left_held;
        logic right_held;
        logic fire_held;
        logic quit_held;
        logic enter_held;
    } stage_flags_t;

    logic                accept;
    logic                is_scan, is_pop;
    logic [CODE_W-1:0]   code;
    logic                make;
    logic [7:0]          typed_char;
    logic                ring_push, ring_pop, ring_full, ring_empty;
    logic [7:0]          ring_rd_data;
    held_keys_t          keys_reg, keys_next;
    stage_flags_t        s1_flags_reg, s1_flags_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_advance;
    logic                m_valid_reg, m_valid_next;
    skf_res_t            m_res_reg, m_res_next;

    // Advance stage 1 whenever the output register is empty or being drained
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    assign is_pop  = (s_req.req_type == REQ_POP);
    assign is_scan = (s_req.req_type == REQ_SCAN) && (s_req.scancode != SC_PREFIX);
    assign code    = s_req.scancode[CODE_W-1:0];
    assign make    = ((s_req.scancode & SC_BREAK) == 8'h00);

    // A shift key itself maps to no character, so the held state before
    // this request picks the table correctly
    assign typed_char = make ? to_ascii(code, keys_reg.lshift || keys_reg.rshift) : 8'h00;

    assign ring_push = accept && is_scan && (typed_char != 8'h00) && !ring_full;
    assign ring_pop  = accept && is_pop && !ring_empty;

    skf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ring_push),
        .push_data (typed_char),
        .pop       (ring_pop),
        .rd_data   (ring_rd_data),
        .full      (ring_full),
        .empty     (ring_empty)
    );

    // Held-key update: make sets, break clears
    always_comb begin
        keys_next = keys_reg;
        if (accept && is_scan) begin
            if (code == KC_UP)     keys_next.up     = make;
            if (code == KC_DOWN)   keys_next.down   = make;
            if (code == KC_LEFT)   keys_next.left   = make;
            if (code == KC_RIGHT)  keys_next.right  = make;
            if (code == KC_Z)      keys_next.z      = make;
            if (code == KC_SPACE)  keys_next.space  = make;
            if (code == KC_Q)      keys_next.q      = make;
            if (code == KC_ESC)    keys_next.esc    = make;
            if (code == KC_ENTER)  keys_next.enter  = make;
            if (code == KC_LSHIFT) keys_next.lshift = make;
            if (code == KC_RSHIFT) keys_next.rshift = make;
        end
    end

    // Capture the result flags with the key states after this request
    always_comb begin
        s1_flags_next.char_valid   = ring_pop;
        s1_flags_next.char_dropped = accept && is_scan && (typed_char != 8'h00) && ring_full;
        s1_flags_next.up_held      = keys_next.up;
        s1_flags_next.down_held    = keys_next.down;
        s1_flags_next.left_held    = keys_next.left;
        s1_flags_next.right_held   = keys_next.right;
        s1_flags_next.fire_held    = keys_next.z || keys_next.space;
        s1_flags_next.quit_held    = keys_next.q || keys_next.esc;
        s1_flags_next.enter_held   = keys_next.enter;
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // Output register: merge ring read data with the stage 1 flags
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (s1_advance) begin
            m_valid_next            = 1'b1;
            m_res_next.char_out     = s1_flags_reg.char_valid ? ring_rd_data : 8'h00;
            m_res_next.char_valid   = s1_flags_reg.char_valid;
            m_res_next.char_dropped = s1_flags_reg.char_dropped;
            m_res_next.up_held      = s1_flags_reg.up_held;
            m_res_next.down_held    = s1_flags_reg.down_held;
            m_res_next.left_held    = s1_flags_reg.left_held;
            m_res_next.right_held   = s1_flags_reg.right_held;
            m_res_next.fire_held    = s1_flags_reg.fire_held;
            m_res_next.quit_held    = s1_flags_reg.quit_held;
            m_res_next.enter_held   = s1_flags_reg.enter_held;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            keys_reg     <= keys_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: hold unless a new request or result lands
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_flags_reg <= s1_flags_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

// ----- hdl/skf_checker.sv -----
// Port-level checks for the keyboard buffer, bound to the top level.
`timescale 1ns / 1ps

module skf_checker
    import skf_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input skf_res_t m_res
);

    // A popped character is never zero: zero codes are never pushed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.char_valid |-> m_res.char_out != 8'h00)
        else $error("popped character is zero");

    // No character without a successful pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_res.char_valid |-> m_res.char_out == 8'h00)
        else $error("character shown without a pop");

    // A pop and a drop cannot come from the same request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_res.char_valid && m_res.char_dropped))
        else $error("pop and drop in one result");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed");

    // With the output empty the input is always open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

endmodule

bind scancode_keyboard_fifo skf_checker u_skf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);
